FILE: rtl/kmd_pkg.sv
// Shared constants, register codes and per-key state type for the key matrix
// debounce block. No dependencies.
package kmd_pkg;

  localparam int ROWS          = 4;
  localparam int COLS          = 8;
  localparam int LAST_ROW_KEYS = 6;
  localparam int NKEYS         = ROWS * COLS;
  localparam int KEY_W         = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  localparam int ROW_W   = 2;
  localparam int COL_W   = 3;
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;
  localparam int NOTE_W  = 7;

  // configuration port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_DELAY = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BASE_NOTE      = REG_IDX_W'(1);

  localparam logic [DELAY_W-1:0] DEBOUNCE_DELAY_RESET = DELAY_W'(1);
  localparam logic [NOTE_W-1:0]  BASE_NOTE_RESET      = NOTE_W'(36);

  typedef struct packed {
    logic [DELAY_W-1:0] debounce_delay;
    logic [NOTE_W-1:0]  base_note;
  } cfg_t;

  typedef struct packed {
    logic              raw_level;
    logic              pressed;
    logic [TIME_W-1:0] change_time;
  } key_state_t;

  localparam int STATE_W = $bits(key_state_t);

endpackage

FILE: rtl/kmd_key_if.sv
// Input channel carrying one sampled key of the matrix.
// Depends on kmd_pkg for field widths.
interface kmd_key_if;
  logic                         valid;
  logic                         ready;
  logic [kmd_pkg::ROW_W-1:0]    row;
  logic [kmd_pkg::COL_W-1:0]    column;
  logic                         key_level;
  logic [kmd_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output row, output column, output key_level,
                  output now_ms, input ready);
  modport sink   (input valid, input row, input column, input key_level,
                  input now_ms, output ready);
endinterface

FILE: rtl/kmd_note_if.sv
// Output channel carrying one note event.
// Depends on kmd_pkg for field widths.
interface kmd_note_if;
  logic                        valid;
  logic                        ready;
  logic [kmd_pkg::NOTE_W-1:0]  note;
  logic                        note_on;

  modport source (output valid, output note, output note_on, input ready);
  modport sink   (input valid, input note, input note_on, output ready);
endinterface

FILE: rtl/kmd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/kmd_regs.sv
// APB-style configuration registers: debounce delay and base note.
// Depends on kmd_pkg for register codes, widths and reset values.
module kmd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kmd_pkg::ADDR_W-1:0]  paddr,
  input  logic [kmd_pkg::DATA_W-1:0]  pwdata,
  output logic [kmd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output kmd_pkg::cfg_t               cfg
);

  logic [kmd_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[kmd_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_delay <= kmd_pkg::DEBOUNCE_DELAY_RESET;
      cfg.base_note      <= kmd_pkg::BASE_NOTE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        kmd_pkg::REG_DEBOUNCE_DELAY: begin
          cfg.debounce_delay <= pwdata[kmd_pkg::DELAY_W-1:0];
        end
        kmd_pkg::REG_BASE_NOTE: begin
          cfg.base_note <= pwdata[kmd_pkg::NOTE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kmd_pkg::REG_DEBOUNCE_DELAY: begin
        prdata = kmd_pkg::DATA_W'(cfg.debounce_delay);
      end
      kmd_pkg::REG_BASE_NOTE: begin
        prdata = kmd_pkg::DATA_W'(cfg.base_note);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

FILE: rtl/key_matrix_debounce_notes_core.sv
// Top level of the key matrix debouncer: per-key state RAM, update stage,
// note output register. Depends on kmd_pkg, kmd_key_if, kmd_note_if,
// kmd_ram and kmd_regs.
//
//  channel   dir  handshake          payload
//  keys      in   valid / ready      row, column, key_level, now_ms
//  notes     out  valid / ready      note, note_on
//  apb       in   psel/penable/...   debounce_delay @0x0, base_note @0x4
//
// One key sample per cycle while the note output is not held; a note is
// offered from the note output register once the update stage fires.
// The state RAM is read on acceptance and written back as the update stage
// fires; a sample of the key just written takes the forwarded entry.
// Reset clears per-key valid bits at once; an unwritten key reads as zero.
// A held note output stalls the update stage and with it the input.
module key_matrix_debounce_notes_core (
  input  logic                        clk,
  input  logic                        rst,
  kmd_key_if.sink                     keys,
  kmd_note_if.source                  notes,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kmd_pkg::ADDR_W-1:0]  paddr,
  input  logic [kmd_pkg::DATA_W-1:0]  pwdata,
  output logic [kmd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  kmd_pkg::cfg_t cfg;

  kmd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // acceptance and key decode
  logic                        accept;
  logic                        key_legal;
  logic [kmd_pkg::KEY_W-1:0]   key_idx;
  logic [kmd_pkg::NOTE_W-1:0]  note_num;

  // update stage
  logic                          s1_valid;
  logic                          s1_fire;
  logic [kmd_pkg::KEY_W-1:0]     s1_key;
  logic                          s1_level;
  logic [kmd_pkg::TIME_W-1:0]    s1_now;
  logic [kmd_pkg::NOTE_W-1:0]    s1_note;

  logic [kmd_pkg::NKEYS-1:0]     key_seen;
  logic                          fwd_valid;
  logic [kmd_pkg::KEY_W-1:0]     fwd_key;
  kmd_pkg::key_state_t           fwd_data;

  logic [kmd_pkg::STATE_W-1:0]   ram_rdata;
  kmd_pkg::key_state_t           cur;
  kmd_pkg::key_state_t           upd;
  logic [kmd_pkg::TIME_W-1:0]    elapsed;
  logic                          emit;

  assign s1_fire    = s1_valid && (!notes.valid || notes.ready);
  assign keys.ready = !s1_valid || s1_fire;
  assign accept     = keys.valid && keys.ready;

  assign key_legal = (int'(keys.row) < kmd_pkg::ROWS) &&
                     (int'(keys.column) < kmd_pkg::COLS) &&
                     !((int'(keys.row) == kmd_pkg::ROWS - 1) &&
                       (int'(keys.column) >= kmd_pkg::LAST_ROW_KEYS));

  assign key_idx  = kmd_pkg::KEY_W'(int'(keys.row) * kmd_pkg::COLS + int'(keys.column));
  assign note_num = kmd_pkg::NOTE_W'(int'(cfg.base_note) +
                                     int'(keys.row) * kmd_pkg::COLS +
                                     int'(keys.column));

  kmd_ram #(
    .WIDTH (kmd_pkg::STATE_W),
    .DEPTH (kmd_pkg::NKEYS)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_key),
    .wdata (upd),
    .re    (accept),
    .raddr (key_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= key_legal;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key   <= key_idx;
      s1_level <= keys.key_level;
      s1_now   <= keys.now_ms;
      s1_note  <= note_num;
    end
  end

  // take the entry written at the read edge, else RAM, else the reset value
  always_comb begin
    if (fwd_valid && (fwd_key == s1_key)) begin
      cur = fwd_data;
    end else if (key_seen[s1_key]) begin
      cur = kmd_pkg::key_state_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  // a level change restarts the timer, and nothing fires on that sample
  assign elapsed = s1_now - cur.change_time;
  assign emit    = (s1_level == cur.raw_level) &&
                   (elapsed > kmd_pkg::TIME_W'(cfg.debounce_delay)) &&
                   (s1_level != cur.pressed);

  always_comb begin
    upd.raw_level   = s1_level;
    upd.change_time = (s1_level != cur.raw_level) ? s1_now : cur.change_time;
    upd.pressed     = emit ? s1_level : cur.pressed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_seen  <= '0;
      fwd_valid <= 1'b0;
    end else if (s1_fire) begin
      key_seen[s1_key] <= 1'b1;
      fwd_valid        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_key  <= s1_key;
      fwd_data <= upd;
    end
  end

  // note output register
  always_ff @(posedge clk) begin
    if (rst) begin
      notes.valid <= 1'b0;
    end else if (s1_fire && emit) begin
      notes.valid <= 1'b1;
    end else if (notes.ready) begin
      notes.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      notes.note    <= s1_note;
      notes.note_on <= s1_level;
    end
  end

endmodule

FILE: bench/tb.sv
// Self-checking bench for key_matrix_debounce_notes_core: drives key samples and
// APB register writes, predicts note events per key and compares each one.
// Depends on kmd_pkg, kmd_key_if, kmd_note_if and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kmd_pkg::*;

  localparam int PLAYABLE_KEYS  = NKEYS - (COLS - LAST_ROW_KEYS);
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic              note_on;
  } note_evt_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  kmd_key_if  key_ch ();
  kmd_note_if note_ch ();

  key_matrix_debounce_notes_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .keys    (key_ch),
    .notes   (note_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // per-key debounce state and register shadow
  cfg_t              cfg_model;
  logic              key_raw [NKEYS];
  logic [TIME_W-1:0] key_changed_at [NKEYS];
  logic              key_pressed [NKEYS];
  note_evt_t         pending_notes [$];

  logic [TIME_W-1:0] now_cur;
  bit  idle_on = 1'b1;
  int  notes_hold_cycles = 0;
  int  mismatches = 0;
  int  keys_sent = 0;
  int  keys_ignored = 0;
  int  notes_seen = 0;
  int  settings_used = 0;
  int  quiet_cycles = 0;

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  function automatic bit key_present(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    return !(int'(r) == ROWS - 1 && int'(c) >= LAST_ROW_KEYS);
  endfunction

  function automatic void predict_note(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                       input logic lvl, input logic [TIME_W-1:0] now);
    int k;
    logic [TIME_W-1:0] held;
    note_evt_t ev;
    if (!key_present(r, c)) return;
    k = int'(r) * COLS + int'(c);
    // a level change restarts the key's timer
    if (lvl != key_raw[k]) key_changed_at[k] = now;
    key_raw[k] = lvl;
    held = now - key_changed_at[k];
    if (held > TIME_W'(cfg_model.debounce_delay) && lvl != key_pressed[k]) begin
      key_pressed[k] = lvl;
      ev.note = NOTE_W'(int'(cfg_model.base_note) + k);
      ev.note_on = lvl;
      pending_notes.push_back(ev);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_key(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                          input logic lvl, input logic [TIME_W-1:0] now);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      key_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    key_ch.row = r;
    key_ch.column = c;
    key_ch.key_level = lvl;
    key_ch.now_ms = now;
    key_ch.valid = 1'b1;
    do @(posedge clk); while (!key_ch.ready);
    predict_note(r, c, lvl, now);
    if (key_present(r, c)) keys_sent++;
    else keys_ignored++;
  endtask

  task automatic pause_until_idle();
    @(negedge clk);
    key_ch.valid = 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    // then wait on for samples that end in no note
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic [REG_IDX_W-1:0] idx, input bit wr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 2'b00};
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (wr) begin
      case (idx)
        REG_DEBOUNCE_DELAY: cfg_model.debounce_delay = wdata[DELAY_W-1:0];
        REG_BASE_NOTE:      cfg_model.base_note = wdata[NOTE_W-1:0];
        default: ;
      endcase
    end
  endtask

  task automatic check_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] got;
    apb_xfer(idx, 1'b0, '0, got);
    if (got !== want)
      note_failure($sformatf("register %0d reads %0h, expected %0h", idx, got, want));
  endtask

  task automatic configure(input logic [DELAY_W-1:0] d, input logic [NOTE_W-1:0] b);
    logic [DATA_W-1:0] unused_rd;
    pause_until_idle();
    apb_xfer(REG_DEBOUNCE_DELAY, 1'b1, DATA_W'(d), unused_rd);
    apb_xfer(REG_BASE_NOTE, 1'b1, DATA_W'(b), unused_rd);
    check_reg(REG_DEBOUNCE_DELAY, DATA_W'(d));
    check_reg(REG_BASE_NOTE, DATA_W'(b));
    settings_used++;
  endtask

  // bounce a key, then hold it past the delay so it settles
  task automatic run_bounce_sequence();
    int k;
    int i;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic lvl;
    logic [TIME_W-1:0] span;
    k = $urandom_range(0, PLAYABLE_KEYS - 1);
    r = ROW_W'(k / COLS);
    c = COL_W'(k % COLS);
    lvl = ($urandom_range(0, 3) != 0) ? !key_pressed[k] : key_pressed[k];
    span = TIME_W'(cfg_model.debounce_delay);
    for (i = $urandom_range(0, 3); i > 0; i--) begin
      send_key(r, c, lvl ^ i[0], now_cur);
      now_cur += $urandom_range(0, span);
    end
    send_key(r, c, lvl, now_cur);
    if ($urandom_range(0, 2) == 0) begin
      // sit exactly on the delay first
      now_cur += span;
      send_key(r, c, lvl, now_cur);
      now_cur += 1;
    end else begin
      now_cur += span + 1 + $urandom_range(0, 3);
    end
    send_key(r, c, lvl, now_cur);
  endtask

  task automatic send_noise();
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic [TIME_W-1:0] t;
    r = ROW_W'($urandom_range(0, ROWS - 1));
    c = COL_W'($urandom_range(0, COLS - 1));
    if ($urandom_range(0, 9) < 7) begin
      now_cur += $urandom_range(0, 3);
      t = now_cur;
    end else begin
      t = $urandom();
    end
    send_key(r, c, 1'($urandom_range(0, 1)), t);
  endtask

  task automatic test_register_defaults();
    check_reg(REG_DEBOUNCE_DELAY, DATA_W'(DEBOUNCE_DELAY_RESET));
    check_reg(REG_BASE_NOTE, DATA_W'(BASE_NOTE_RESET));
  endtask

  task automatic test_default_debounce();
    send_key(2'd0, 3'd0, 1'b1, 32'd100);
    send_key(2'd0, 3'd0, 1'b1, 32'd101);
    send_key(2'd0, 3'd0, 1'b1, 32'd102);
    send_key(2'd0, 3'd0, 1'b0, 32'd110);
    send_key(2'd0, 3'd0, 1'b0, 32'd112);
  endtask

  task automatic test_note_wrap_and_missing_keys();
    configure(16'd0, 7'd127);
    send_key(2'd0, 3'd1, 1'b1, 32'd200);
    send_key(2'd0, 3'd1, 1'b1, 32'd201);
    send_key(2'd3, 3'd5, 1'b1, 32'd202);
    send_key(2'd3, 3'd5, 1'b1, 32'd203);
    // absent keys in the last row: no state, no note
    send_key(2'd3, 3'd6, 1'b1, 32'd300);
    send_key(2'd3, 3'd6, 1'b1, 32'd310);
    send_key(2'd3, 3'd7, 1'b1, 32'd300);
    send_key(2'd3, 3'd7, 1'b1, 32'd310);
  endtask

  task automatic test_time_wrap_and_bounce();
    configure(16'hFFFF, 7'd98);
    send_key(2'd2, 3'd7, 1'b1, 32'hFFFF_0000);
    send_key(2'd2, 3'd7, 1'b1, 32'hFFFF_FFFF);
    send_key(2'd2, 3'd7, 1'b1, 32'h0000_0000);
    // time running backwards reads as a huge elapsed time
    send_key(2'd1, 3'd3, 1'b1, 32'd1000);
    send_key(2'd1, 3'd3, 1'b1, 32'd999);
    send_key(2'd1, 3'd3, 1'b1, 32'd5);
    send_key(2'd0, 3'd4, 1'b1, 32'd10);
    send_key(2'd0, 3'd4, 1'b0, 32'd20);
    send_key(2'd0, 3'd4, 1'b1, 32'd30);
    send_key(2'd0, 3'd4, 1'b1, 32'd30 + 32'd65536);
  endtask

  task automatic test_backpressure();
    int k;
    int i;
    logic lvl;
    configure(16'd0, NOTE_W'($urandom_range(0, 98)));
    idle_on = 1'b0;
    notes_hold_cycles = 200;
    for (i = 0; i < 40; i++) begin
      k = $urandom_range(0, PLAYABLE_KEYS - 1);
      lvl = !key_pressed[k];
      send_key(ROW_W'(k / COLS), COL_W'(k % COLS), lvl, now_cur);
      now_cur += 1;
      send_key(ROW_W'(k / COLS), COL_W'(k % COLS), lvl, now_cur);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_settings();
    int phase;
    int target;
    logic [DELAY_W-1:0] d;
    logic [NOTE_W-1:0] b;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin d = '0; b = '0; end
        1: begin d = '1; b = 7'd98; end
        2: begin d = 16'd1; b = BASE_NOTE_RESET; end
        3: begin
          d = DELAY_W'($urandom_range(2, 40));
          b = NOTE_W'($urandom_range(0, 98));
        end
        default: begin
          d = DELAY_W'($urandom_range(0, 6));
          b = NOTE_W'($urandom_range(0, 98));
        end
      endcase
      configure(d, b);
      idle_on = (phase != 3);
      now_cur = $urandom();
      target = keys_sent + 130;
      while (keys_sent < target) begin
        if ($urandom_range(0, 99) < 80) run_bounce_sequence();
        else send_noise();
      end
    end
    idle_on = 1'b1;
  endtask

  // note receiver: random stalls, or a long hold-off when asked
  initial begin : notes_receiver
    int stall_left;
    int r;
    stall_left = 0;
    note_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (notes_hold_cycles > 0) begin
        note_ch.ready = 1'b0;
        repeat (notes_hold_cycles - 1) @(negedge clk);
        notes_hold_cycles = 0;
      end else if (!idle_on) begin
        note_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        note_ch.ready = 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          note_ch.ready = 1'b1;
        end else begin
          note_ch.ready = 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin : check_notes
    note_evt_t want;
    if (!rst && note_ch.valid && note_ch.ready) begin
      notes_seen++;
      if (pending_notes.size() == 0) begin
        note_failure($sformatf("unexpected note %0d on %0b", note_ch.note, note_ch.note_on));
      end else begin
        want = pending_notes.pop_front();
        if (note_ch.note !== want.note || note_ch.note_on !== want.note_on)
          note_failure($sformatf("note mismatch: expected note %0d on %0b, got note %0d on %0b",
                                 want.note, want.note_on, note_ch.note, note_ch.note_on));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (key_ch.valid && key_ch.ready) || (note_ch.valid && note_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    key_ch.valid = 1'b0;
    key_ch.row = '0;
    key_ch.column = '0;
    key_ch.key_level = 1'b0;
    key_ch.now_ms = '0;
    cfg_model.debounce_delay = DEBOUNCE_DELAY_RESET;
    cfg_model.base_note = BASE_NOTE_RESET;
    foreach (key_raw[i]) begin
      key_raw[i] = 1'b0;
      key_changed_at[i] = '0;
      key_pressed[i] = 1'b0;
    end
    now_cur = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_defaults();
    test_default_debounce();
    test_note_wrap_and_missing_keys();
    test_time_wrap_and_bounce();
    test_backpressure();
    test_random_settings();

    pause_until_idle();
    repeat (8) @(posedge clk);
    if (pending_notes.size() != 0)
      note_failure($sformatf("%0d notes never arrived", pending_notes.size()));
    $display("Run covered %0d key samples plus %0d on absent keys, %0d note events,",
             keys_sent, keys_ignored, notes_seen);
    $display("over %0d register settings including a long receiver hold-off; %0d mismatches",
             settings_used, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
